[src/cttm_pkg.sv]
// Shared types and constants for the clock time token matcher.
// Holds the per-byte class record passed from the byte lanes to the merge stage.
// Depends on nothing.
`default_nettype none

package cttm_pkg;

    localparam int WIN_BYTES    = 12;
    localparam int AVAIL_WIDTH  = 4;
    localparam int OFFSET_WIDTH = 16;
    localparam int LEN_WIDTH    = 4;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_UP_M  = 8'h4D;
    localparam logic [7:0] CH_LO_M  = 8'h6D;
    localparam logic [7:0] CH_UP_P  = 8'h50;
    localparam logic [7:0] CH_LO_P  = 8'h70;

    // A minute or second field runs to 59, so its tens digit is at most 5.
    localparam logic [3:0] FIELD_TENS_MAX = 4'd5;
    localparam logic [6:0] HOUR12_MAX     = 7'd12;
    localparam logic [6:0] HOUR24_MAX     = 7'd23;

    typedef struct packed {
        logic       digit;
        logic       colon;
        logic       space;
        logic       letter;
        logic       ap;
        logic       m;
        logic [3:0] value;
    } t_byte_class;

    typedef struct packed {
        logic                 matched;
        logic [LEN_WIDTH-1:0] length;
    } t_match;

endpackage

`default_nettype wire

[src/cttm_lane.sv]
// One byte lane: classifies a single window byte for the token parser.
// Depends on cttm_pkg.
`default_nettype none

module cttm_lane (
    input  var logic [7:0]            i_byte,
    input  var logic                  i_present,
    output cttm_pkg::t_byte_class     o_class
);

    logic is_upper;
    logic is_lower;

    always_comb begin
        is_upper = (i_byte >= cttm_pkg::CH_UP_A) && (i_byte <= cttm_pkg::CH_UP_Z);
        is_lower = (i_byte >= cttm_pkg::CH_LO_A) && (i_byte <= cttm_pkg::CH_LO_Z);

        // An absent byte past the end of the text matches no class at all.
        o_class.digit  = i_present && (i_byte >= cttm_pkg::CH_ZERO)
                         && (i_byte <= cttm_pkg::CH_NINE);
        o_class.colon  = i_present && (i_byte == cttm_pkg::CH_COLON);
        o_class.space  = i_present && (i_byte == cttm_pkg::CH_SPACE);
        o_class.letter = i_present && (is_upper || is_lower);
        o_class.ap     = i_present && ((i_byte == cttm_pkg::CH_UP_A)
                         || (i_byte == cttm_pkg::CH_LO_A)
                         || (i_byte == cttm_pkg::CH_UP_P)
                         || (i_byte == cttm_pkg::CH_LO_P));
        o_class.m      = i_present && ((i_byte == cttm_pkg::CH_UP_M)
                         || (i_byte == cttm_pkg::CH_LO_M));
        o_class.value  = i_byte[3:0];
    end

endmodule

`default_nettype wire

[src/cttm_merge.sv]
// Merge stage: combines the byte lane classes into a match decision and length.
// Depends on cttm_pkg.
`default_nettype none

module cttm_merge (
    input  var cttm_pkg::t_byte_class [cttm_pkg::WIN_BYTES-1:0] i_cls,
    output cttm_pkg::t_match                                     o_match
);

    localparam int REL_BYTES = cttm_pkg::WIN_BYTES - 2;

    cttm_pkg::t_byte_class [REL_BYTES-1:0] c;
    logic       hp2;
    logic [6:0] hour;
    logic       colon;
    logic       field1;
    logic       field2;
    logic       bad;
    logic       ampm;
    logic       hour_ok;
    logic [3:0] rel;
    logic [3:0] mark;
    logic [3:0] pos;

    always_comb begin
        // Everything after the hour is parsed relative to the first byte past it.
        hp2 = i_cls[1].digit;
        for (int k = 0; k < REL_BYTES; k++) begin
            c[k] = hp2 ? i_cls[k + 2] : i_cls[k + 1];
        end

        hour = hp2 ? (({3'd0, i_cls[0].value} << 3) + ({3'd0, i_cls[0].value} << 1)
                      + {3'd0, i_cls[1].value})
                   : {3'd0, i_cls[0].value};

        colon  = c[0].colon;
        field1 = c[1].digit && c[2].digit && (c[1].value <= cttm_pkg::FIELD_TENS_MAX);
        field2 = c[4].digit && c[5].digit && (c[4].value <= cttm_pkg::FIELD_TENS_MAX);

        // A colon that is not followed by a valid field rejects the whole token.
        bad = c[0].digit || (colon && !field1) || (colon && c[3].colon && !field2);

        if (!colon) begin
            rel = 4'd0;
        end else if (c[3].colon) begin
            rel = 4'd6;
        end else begin
            rel = 4'd3;
        end

        mark = rel + {3'd0, c[rel].space};
        ampm = c[mark].ap && c[mark + 4'd1].m;
        pos  = ampm ? (mark + 4'd2) : rel;

        hour_ok = ampm ? ((hour != 7'd0) && (hour <= cttm_pkg::HOUR12_MAX))
                       : (hour <= cttm_pkg::HOUR24_MAX);

        o_match.matched = i_cls[0].digit && !bad && (colon || ampm) && hour_ok
                          && !c[pos].letter;
        o_match.length  = o_match.matched ? (pos + (hp2 ? 4'd2 : 4'd1)) : 4'd0;
    end

endmodule

`default_nettype wire

[src/clock_time_token_matcher.sv]
// Top level of the clock time token matcher: byte lanes, class register,
// merge stage and result register. Depends on cttm_pkg, cttm_lane and cttm_merge.
//
// Usage: drive a 12-byte text window, the number of bytes present and the
// window's start offset, and pulse i_start. o_busy is always low, so a new
// item is taken on every cycle in which i_start is high.
// Twelve byte lanes classify the window in parallel and their classes are
// registered; the merge stage then decides the match and its length, which
// is registered onto the result ports.
// The result of an accepted item passes the class register and the result
// register, and is shown on the result ports marked by o_done for exactly
// one cycle.
// Throughput: one item per cycle, set by the two-stage lane/merge pipeline.
// The receiver cannot hold results off; results are never delayed.
// o_match_start echoes the start offset masked to OFFSET_BITS.
// Reset (synchronous, active low) empties the pipeline; items in flight
// are dropped and o_done stays low until new items arrive.
`default_nettype none

module clock_time_token_matcher #(
    parameter int OFFSET_BITS = 16
) (
    input  var logic                                 i_clk,
    input  var logic                                 i_rst_n,
    input  var logic                                 i_start,
    output logic                                     o_busy,
    input  var logic [63:0]                          i_window_low,
    input  var logic [31:0]                          i_window_high,
    input  var logic [cttm_pkg::AVAIL_WIDTH-1:0]     i_bytes_available,
    input  var logic [cttm_pkg::OFFSET_WIDTH-1:0]    i_start_offset,
    output logic                                     o_done,
    output logic                                     o_matched,
    output logic [cttm_pkg::LEN_WIDTH-1:0]           o_token_length,
    output logic [cttm_pkg::OFFSET_WIDTH-1:0]        o_match_start
);

    localparam int KEEP_BITS = (OFFSET_BITS < cttm_pkg::OFFSET_WIDTH)
                               ? OFFSET_BITS : cttm_pkg::OFFSET_WIDTH;
    localparam logic [cttm_pkg::OFFSET_WIDTH:0] MASK_WIDE =
        ((cttm_pkg::OFFSET_WIDTH + 1)'(1) << KEEP_BITS) - (cttm_pkg::OFFSET_WIDTH + 1)'(1);
    localparam logic [cttm_pkg::OFFSET_WIDTH-1:0] START_MASK =
        MASK_WIDE[cttm_pkg::OFFSET_WIDTH-1:0];

    logic [95:0]                                      window;
    cttm_pkg::t_byte_class [cttm_pkg::WIN_BYTES-1:0]  lane_cls;
    cttm_pkg::t_byte_class [cttm_pkg::WIN_BYTES-1:0]  r_cls;
    cttm_pkg::t_match                                 merged;

    logic                                r_v1;
    logic                                n_v1;
    logic [cttm_pkg::OFFSET_WIDTH-1:0]   r_off1;
    logic                                r_done;
    logic                                n_done;
    logic                                r_matched;
    logic [cttm_pkg::LEN_WIDTH-1:0]      r_len;
    logic [cttm_pkg::OFFSET_WIDTH-1:0]   r_start;

    assign window = {i_window_high, i_window_low};

    for (genvar g = 0; g < cttm_pkg::WIN_BYTES; g++) begin : g_lane
        cttm_lane u_lane (
            .i_byte    (window[8*g +: 8]),
            .i_present (i_bytes_available > cttm_pkg::AVAIL_WIDTH'(g)),
            .o_class   (lane_cls[g])
        );
    end

    cttm_merge u_merge (
        .i_cls   (r_cls),
        .o_match (merged)
    );

    always_comb begin
        n_v1   = i_start && !o_busy;
        n_done = r_v1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= n_v1;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cls     <= lane_cls;
        r_off1    <= i_start_offset & START_MASK;
        r_matched <= merged.matched;
        r_len     <= merged.length;
        r_start   <= r_off1;
    end

    assign o_busy         = 1'b0;
    assign o_done         = r_done;
    assign o_matched      = r_matched;
    assign o_token_length = r_len;
    assign o_match_start  = r_start;

    a_flag_len : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_matched == (o_token_length != '0)))
        else $error("match flag disagrees with token length");

    a_len_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_matched) |-> ((o_token_length >= 4'd3) && (o_token_length <= 4'd11)))
        else $error("matched token length out of range");

    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##2 o_done)
        else $error("accepted item produced no result two cycles later");

    a_no_spurious : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_v1))
        else $error("result strobe without an item in the pipeline");

endmodule

`default_nettype wire
